### rtl/kst_pkg.sv
package kst_pkg;

  // Fixed field widths of the request and response
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Default sizing
  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_GET    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

endpackage

### rtl/kst_if.sv
interface kst_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic signed [kst_pkg::KEY_W-1:0]   key_id;
  logic [kst_pkg::HANDLE_W-1:0]       entry_handle;

  modport source (output valid, output mode, output key_id, output entry_handle,
                  input ready);
  modport sink   (input valid, input mode, input key_id, input entry_handle,
                  output ready);
endinterface

interface kst_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [kst_pkg::STATUS_W-1:0]       status;
  logic signed [kst_pkg::KEY_W-1:0]   result_id;
  logic [kst_pkg::HANDLE_W-1:0]       result_handle;
  logic [kst_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, output status, output result_id,
                  output result_handle, output entry_count, input ready);
  modport sink   (input valid, input status, input result_id,
                  input result_handle, input entry_count, output ready);
endinterface

### rtl/kst_ram.sv
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/keyed_set_table.sv
// Channel  Dir  Fields                                              Accepted when
// -------  ---  --------------------------------------------------  -------------------
// req      in   mode, key_id, entry_handle                          req.valid & ready
// rsp      out  status, result_id, result_handle, entry_count       rsp.valid & ready
//
// Entries sit in a RAM with a registered read: each scanned entry takes an
// address step, then a compare step; each entry moved down after a remove takes a
// read step, then a write step; pop reads the last slot. One request at a time.
// rst (synchronous) empties the table; RAM is not cleared. The next request runs
// while a response waits in the output register and holds at its finish till it drains.
module keyed_set_table #(
  parameter int DEPTH       = kst_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = kst_pkg::HANDLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kst_req_if.sink   req,
  kst_rsp_if.source rsp
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = kst_pkg::KEY_W + HANDLE_BITS;
  localparam int HXW = HANDLE_BITS + kst_pkg::HANDLE_W;
  localparam int CXW = CW + kst_pkg::COUNT_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,  // issue read of scan slot
    S_CMP   = 9'b000000100,  // compare slot key
    S_APP   = 9'b000001000,  // append new entry
    S_SHRD  = 9'b000010000,  // read entry above the gap
    S_SHWR  = 9'b000100000,  // move it down
    S_POPRD = 9'b001000000,
    S_POPDT = 9'b010000000,
    S_FIN   = 9'b100000000   // hand result to output register
  } state_t;

  state_t state;

  // Request held for the duration of the operation
  kst_pkg::mode_t                op;
  logic [kst_pkg::KEY_W-1:0]     op_key;
  logic [HANDLE_BITS-1:0]        op_handle;

  logic [AW-1:0] idx;
  logic [CW-1:0] count;

  // Result being built
  kst_pkg::status_t              res_status;
  logic [kst_pkg::KEY_W-1:0]     res_id;
  logic [kst_pkg::HANDLE_W-1:0]  res_handle;

  // Output register
  logic                          out_valid;
  kst_pkg::status_t              out_status;
  logic [kst_pkg::KEY_W-1:0]     out_id;
  logic [kst_pkg::HANDLE_W-1:0]  out_handle;
  logic [kst_pkg::COUNT_W-1:0]   out_count;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [kst_pkg::KEY_W-1:0]    rd_key;
  logic [HXW-1:0]               rd_handle_ext;
  logic [kst_pkg::HANDLE_W-1:0] rd_handle;
  logic [HXW-1:0]               in_handle_ext;
  logic [CXW-1:0]               count_ext;

  logic          key_hit;
  logic          more_scan;   // another slot left to compare
  logic          more_shift;  // another entry left to move down
  logic          full;

  assign rd_key        = ram_rdata[EW-1 -: kst_pkg::KEY_W];
  assign rd_handle_ext = HXW'(ram_rdata[HANDLE_BITS-1:0]);
  assign rd_handle     = rd_handle_ext[kst_pkg::HANDLE_W-1:0];
  assign in_handle_ext = HXW'(req.entry_handle);
  assign count_ext     = CXW'(count);

  assign key_hit    = (rd_key == op_key);
  assign more_scan  = ((CW + 1)'(idx) + (CW + 1)'(1)) < (CW + 1)'(count);
  assign more_shift = ((CW + 1)'(idx) + (CW + 1)'(2)) < (CW + 1)'(count);
  assign full       = (count == CW'(DEPTH));

  // RAM addressing: scan reads idx, shift reads idx+1, pop reads the last slot
  always_comb begin
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    unique case (state)
      S_SHRD:  ram_raddr = AW'((CW + 1)'(idx) + (CW + 1)'(1));
      S_POPRD: ram_raddr = AW'(count - CW'(1));
      S_APP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(count);
        ram_wdata = {op_key, op_handle};
      end
      S_SHWR:  ram_we = 1'b1;
      default: ram_raddr = idx;
    endcase
  end

  kst_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= kst_pkg::mode_t'(req.mode);
            op_key     <= req.key_id;
            op_handle  <= in_handle_ext[HANDLE_BITS-1:0];
            idx        <= '0;
            res_status <= kst_pkg::ST_OK;
            res_id     <= '0;
            res_handle <= '0;
            if (kst_pkg::mode_t'(req.mode) == kst_pkg::MODE_POP) begin
              if (count == '0) begin
                res_status <= kst_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                state <= S_POPRD;
              end
            end else if (count != '0) begin
              state <= S_RD;
            end else if (kst_pkg::mode_t'(req.mode) == kst_pkg::MODE_ADD) begin
              state <= S_APP;
            end else begin
              res_status <= kst_pkg::ST_NOTFOUND;
              state      <= S_FIN;
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (key_hit) begin
            if (op == kst_pkg::MODE_ADD) begin
              res_status <= kst_pkg::ST_PRESENT;
              state      <= S_FIN;
            end else begin
              res_id     <= rd_key;
              res_handle <= rd_handle;
              if (op == kst_pkg::MODE_REMOVE) begin
                if (more_scan) begin
                  state <= S_SHRD;
                end else begin
                  count <= count - CW'(1);
                  state <= S_FIN;
                end
              end else begin
                state <= S_FIN;
              end
            end
          end else if (more_scan) begin
            idx   <= idx + AW'(1);
            state <= S_RD;
          end else if (op == kst_pkg::MODE_ADD) begin
            if (full) begin
              res_status <= kst_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              state <= S_APP;
            end
          end else begin
            res_status <= kst_pkg::ST_NOTFOUND;
            state      <= S_FIN;
          end
        end
        S_APP: begin
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          idx <= idx + AW'(1);
          if (more_shift) begin
            state <= S_SHRD;
          end else begin
            count <= count - CW'(1);
            state <= S_FIN;
          end
        end
        S_POPRD: begin
          count <= count - CW'(1);
          state <= S_POPDT;
        end
        S_POPDT: begin
          res_id     <= rd_key;
          res_handle <= rd_handle;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loaded from S_FIN once the previous response is gone
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_handle <= res_handle;
      out_count  <= count_ext[kst_pkg::COUNT_W-1:0];
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.result_id     = out_id;
  assign rsp.result_handle = out_handle;
  assign rsp.entry_count   = out_count;

endmodule
